>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(name, clk, rst_n, pre, post)
`define ASSERT_NXT(name, clk, rst_n, pre, post)
`endif

`endif

>>> src/dmt_pkg.sv
// ----------------------------------------------------------------------------
// Tagged entry table package
// Beat types, table word layout, codes and constants shared by the block.
// ----------------------------------------------------------------------------
package dmt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned TAG_LSB    = 27;
  localparam int unsigned TAG_W      = 37;
  localparam int unsigned MOD_STEP   = 8;
  localparam int unsigned MOD_CYCLES = KEY_W / MOD_STEP;

  localparam logic [2:0] MOVE_NONE   = 3'd7;
  localparam logic [2:0] MOVE_MIRROR = 3'd6;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_MIRROR = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    WK_NONE    = 2'd0,
    WK_EMPTY   = 2'd1,
    WK_SAME    = 2'd2,
    WK_COLLIDE = 2'd3
  } wkind_e;

  typedef enum logic {
    FS_IDLE,
    FS_HASH
  } front_state_e;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_EVAL
  } back_state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  alt_key;
    logic signed [15:0] score;
    logic [5:0]        depth;
    logic [1:0]        flag;
    logic [2:0]        best_move;
  } in_beat_t;

  typedef struct packed {
    logic              hit;
    logic              from_mirror;
    logic signed [15:0] found_score;
    logic [5:0]        found_depth;
    logic [1:0]        found_flag;
    logic [2:0]        found_move;
    logic [1:0]        write_kind;
  } out_beat_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic signed [15:0] score;
    logic [5:0]        depth;
    logic [1:0]        flag;
    logic [2:0]        mv;
  } entry_t;

  typedef struct packed {
    action_e           op;
    logic [TAG_W-1:0]  alt_tag;
    entry_t            entry;
  } cmd_t;

endpackage

>>> src/dmt_mod_unit.sv
// ----------------------------------------------------------------------------
// Slot index unit
// Reduces a 64-bit key modulo the table size, eight bits per cycle, or by
// masking when the size is a power of two.
// ----------------------------------------------------------------------------
module dmt_mod_unit #(
  parameter int unsigned ENTRIES = dmt_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W  = $clog2(ENTRIES)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [dmt_pkg::KEY_W-1:0] key_i,
  output logic                     busy_o,
  output logic [IDX_W-1:0]         idx_o
);
  import dmt_pkg::*;

  localparam bit POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);
  localparam logic [IDX_W:0] MODV = (IDX_W + 1)'(ENTRIES);
  localparam int unsigned CNT_W = $clog2(MOD_CYCLES);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0] sh_q, sh_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0] step_rem;

  always_comb begin
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] r;
    r = rem_q;
    for (int j = 0; j < MOD_STEP; j++) begin
      t = {r, sh_q[KEY_W-1-j]};
      if (t >= MODV) begin
        t = t - MODV;
      end
      r = t[IDX_W-1:0];
    end
    step_rem = r;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      if (POW2) begin
        rem_d  = key_i[IDX_W-1:0];
        busy_d = 1'b0;
      end else begin
        rem_d  = '0;
        sh_d   = key_i;
        cnt_d  = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = step_rem;
      sh_d  = sh_q << MOD_STEP;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(MOD_CYCLES - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign idx_o  = rem_q;

endmodule

>>> src/dmt_front.sv
// ----------------------------------------------------------------------------
// Tagged entry table front end
// Accepts input beats, decodes the action and computes both slot indices
// before handing a command to the queue.
// ----------------------------------------------------------------------------
module dmt_front #(
  parameter int unsigned ENTRIES = dmt_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W  = $clog2(ENTRIES),
  localparam int unsigned QW     = 2 * IDX_W + $bits(dmt_pkg::cmd_t)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dmt_pkg::in_beat_t in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output logic [QW-1:0]     push_data_o
);
  import dmt_pkg::*;

  front_state_e     state_q, state_d;
  cmd_t             cmd_q;
  logic             in_fire;
  logic             busy_a, busy_b;
  logic [IDX_W-1:0] idx_a, idx_b;

  dmt_mod_unit #(.ENTRIES(ENTRIES)) u_mod_key (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .key_i   (in_data_i.key),
    .busy_o  (busy_a),
    .idx_o   (idx_a)
  );

  dmt_mod_unit #(.ENTRIES(ENTRIES)) u_mod_alt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .key_i   (in_data_i.alt_key),
    .busy_o  (busy_b),
    .idx_o   (idx_b)
  );

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      FS_IDLE: begin
        in_ready_o = en_i;
        if (in_valid_i && en_i) begin
          state_d = FS_HASH;
        end
      end
      FS_HASH: begin
        push_valid_o = !busy_a && !busy_b;
        if (push_valid_o && push_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  assign in_fire     = in_valid_i && in_ready_o;
  assign push_data_o = {idx_a, idx_b, cmd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q.op          <= action_e'(in_data_i.action);
      cmd_q.alt_tag     <= in_data_i.alt_key[TAG_LSB +: TAG_W];
      cmd_q.entry.tag   <= in_data_i.key[TAG_LSB +: TAG_W];
      cmd_q.entry.score <= in_data_i.score;
      cmd_q.entry.depth <= in_data_i.depth;
      cmd_q.entry.flag  <= in_data_i.flag;
      cmd_q.entry.mv    <= in_data_i.best_move;
    end
  end

endmodule

>>> src/dmt_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module dmt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dmt_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import dmt_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> src/dmt_back.sv
// ----------------------------------------------------------------------------
// Tagged entry table back end
// Owns the table memory: clears it after reset, reads both slots of each
// command, compares tags, writes back and holds the result beat.
// ----------------------------------------------------------------------------
module dmt_back #(
  parameter int unsigned ENTRIES = dmt_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W  = $clog2(ENTRIES),
  localparam int unsigned QW     = 2 * IDX_W + $bits(dmt_pkg::cmd_t)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  logic [QW-1:0]      pop_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dmt_pkg::out_beat_t out_data_o,
  output logic               clr_busy_o
);
  import dmt_pkg::*;

  localparam int unsigned CW = $bits(cmd_t);

  entry_t           mem [ENTRIES];
  entry_t           rd_a_q, rd_b_q;
  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [IDX_W-1:0] idx_a_q;
  cmd_t             cmd_q;
  out_beat_t        out_q, res;
  logic             out_valid_q, out_valid_d;
  logic             pop, load, rd_en, we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic             hit_a, hit_b;

  assign hit_a = (rd_a_q.tag == cmd_q.entry.tag);
  assign hit_b = (rd_b_q.tag == cmd_q.alt_tag);

  always_comb begin
    res = '0;
    case (cmd_q.op)
      ACT_READ: begin
        res.hit         = hit_a;
        res.found_score = rd_a_q.score;
        res.found_depth = rd_a_q.depth;
        res.found_flag  = rd_a_q.flag;
        res.found_move  = rd_a_q.mv;
      end
      ACT_WRITE: begin
        if (rd_a_q == '0) begin
          res.write_kind = WK_EMPTY;
        end else if (hit_a) begin
          res.write_kind = WK_SAME;
        end else begin
          res.write_kind = WK_COLLIDE;
        end
      end
      ACT_MIRROR: begin
        if (hit_a) begin
          res.hit         = 1'b1;
          res.found_score = rd_a_q.score;
          res.found_depth = rd_a_q.depth;
          res.found_flag  = rd_a_q.flag;
          res.found_move  = rd_a_q.mv;
        end else if (hit_b) begin
          res.hit         = 1'b1;
          res.from_mirror = 1'b1;
          res.found_score = rd_b_q.score;
          res.found_depth = rd_b_q.depth;
          res.found_flag  = rd_b_q.flag;
          res.found_move  = (rd_b_q.mv == MOVE_NONE) ? MOVE_NONE : MOVE_MIRROR - rd_b_q.mv;
        end else begin
          res.found_move = MOVE_NONE;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pop_ready_o = 1'b0;
    load        = 1'b0;
    we          = 1'b0;
    waddr       = idx_a_q;
    wdata       = cmd_q.entry;
    case (state_q)
      BS_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == IDX_W'(ENTRIES - 1)) begin
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          state_d = BS_EVAL;
        end
      end
      BS_EVAL: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          we      = (cmd_q.op == ACT_WRITE);
          state_d = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  assign pop   = pop_valid_i && pop_ready_o;
  assign rd_en = pop;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      idx_a_q <= pop_data_i[QW-1 -: IDX_W];
      cmd_q   <= pop_data_i[CW-1:0];
    end
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_a_q <= mem[pop_data_i[QW-1 -: IDX_W]];
      rd_b_q <= mem[pop_data_i[QW-IDX_W-1 -: IDX_W]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign clr_busy_o  = (state_q == BS_CLEAR);

endmodule

>>> src/direct_mapped_tagged_entry_table.sv
// ----------------------------------------------------------------------------
// Direct-mapped tagged entry table
// Each input beat reads, writes or mirror-reads the slot of key modulo
// TABLE_ENTRIES (mirror reads also alt_key's) and gives one result beat.
//
// Input beats arrive on in_valid_i/in_ready_o with an in_beat_t payload;
// result beats leave on out_valid_o/out_ready_i as out_beat_t.
// After reset the table is cleared to zero, one slot per cycle, through
// all TABLE_ENTRIES slots; no input beat is taken until that pass is done.
// The front end takes one beat and reduces key and alt_key to slot indices:
// by masking when TABLE_ENTRIES is a power of two, otherwise eight key bits
// per cycle. It takes no new beat until the command of the last one has
// been pushed into the queue.
// The back end reads both slots from a dual-read memory, then compares
// tags and writes back; it pops the next command only after the last one
// has been loaded into the result register.
// A stalled receiver holds the result register; the back end stops, the
// two-entry command queue fills and then the front end stops accepting.
// ----------------------------------------------------------------------------
module direct_mapped_tagged_entry_table #(
  parameter int unsigned TABLE_ENTRIES = dmt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned QUEUE_DEPTH   = dmt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dmt_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dmt_pkg::out_beat_t out_data_o
);
  import dmt_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned QW    = 2 * IDX_W + $bits(cmd_t);

  logic          clr_busy;
  logic          q_push_valid, q_push_ready;
  logic [QW-1:0] q_push_data;
  logic          q_pop_valid, q_pop_ready;
  logic [QW-1:0] q_pop_data;

  dmt_front #(.ENTRIES(TABLE_ENTRIES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (!clr_busy),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  dmt_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  dmt_back #(.ENTRIES(TABLE_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .clr_busy_o  (clr_busy)
  );

  `ASSERT_IMP(a_no_accept_in_clear, clk_i, rst_ni, clr_busy, !in_ready_o)
  `ASSERT_IMP(a_no_pop_in_clear, clk_i, rst_ni, clr_busy, !(q_pop_valid && q_pop_ready))
  `ASSERT_NXT(a_front_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_NXT(a_back_one_at_a_time, clk_i, rst_ni, q_pop_valid && q_pop_ready, !q_pop_ready)

endmodule

>>> test/entry_table_checker.sv
// ----------------------------------------------------------------------------
// Tagged entry table checker
// Watches both beat channels of the table, keeps its own copy of the table
// words, works out the result beat of every accepted input beat and compares
// each accepted result beat with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module entry_table_checker #(
  parameter int unsigned TABLE_ENTRIES = dmt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  dmt_pkg::in_beat_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  dmt_pkg::out_beat_t out_data_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  import dmt_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  bit [63:0] slot_words [TABLE_ENTRIES];
  out_beat_t pending_lookups [$];

  function automatic out_beat_t slot_fields(entry_t e, logic hit, logic mirrored);
    out_beat_t r;
    r = '0;
    r.hit         = hit;
    r.from_mirror = mirrored;
    r.found_score = e.score;
    r.found_depth = e.depth;
    r.found_flag  = e.flag;
    if (mirrored && e.mv != MOVE_NONE) begin
      r.found_move = MOVE_MIRROR - e.mv;
    end else begin
      r.found_move = e.mv;
    end
    return r;
  endfunction

  function automatic out_beat_t table_access(in_beat_t beat);
    entry_t           key_entry;
    entry_t           alt_entry;
    logic [TAG_W-1:0] key_tag;
    logic [TAG_W-1:0] alt_tag;
    int unsigned      key_slot;
    int unsigned      alt_slot;
    out_beat_t        r;
    r         = '0;
    key_slot  = 32'(beat.key % 64'(TABLE_ENTRIES));
    alt_slot  = 32'(beat.alt_key % 64'(TABLE_ENTRIES));
    key_tag   = beat.key[KEY_W-1:TAG_LSB];
    alt_tag   = beat.alt_key[KEY_W-1:TAG_LSB];
    key_entry = entry_t'(slot_words[key_slot]);
    alt_entry = entry_t'(slot_words[alt_slot]);
    case (beat.action)
      ACT_READ: begin
        r = slot_fields(key_entry, key_entry.tag == key_tag, 1'b0);
      end
      ACT_WRITE: begin
        if (key_entry == '0) begin
          r.write_kind = WK_EMPTY;
        end else if (key_entry.tag != key_tag) begin
          r.write_kind = WK_COLLIDE;
        end else begin
          r.write_kind = WK_SAME;
        end
        slot_words[key_slot] = {key_tag, beat.score, beat.depth, beat.flag, beat.best_move};
      end
      ACT_MIRROR: begin
        if (key_entry.tag == key_tag) begin
          r = slot_fields(key_entry, 1'b1, 1'b0);
        end else if (alt_entry.tag == alt_tag) begin
          r = slot_fields(alt_entry, 1'b1, 1'b1);
        end else begin
          r.found_move = MOVE_NONE;
        end
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic string beat_text(out_beat_t b);
    return $sformatf("hit=%0d mirror=%0d score=%0d depth=%0d flag=%0d move=%0d kind=%0d",
                     b.hit, b.from_mirror, $signed(b.found_score), b.found_depth,
                     b.found_flag, b.found_move, b.write_kind);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t want;
    if (!rst_ni) begin
      pending_lookups.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_lookups.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT) begin
            $display("Result beat with nothing outstanding: %s", beat_text(out_data_i));
          end
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = pending_lookups.pop_front();
          checked_o <= checked_o + 1;
          if (want.hit !== out_data_i.hit || want.from_mirror !== out_data_i.from_mirror ||
              want.found_score !== out_data_i.found_score ||
              want.found_depth !== out_data_i.found_depth ||
              want.found_flag !== out_data_i.found_flag ||
              want.found_move !== out_data_i.found_move ||
              want.write_kind !== out_data_i.write_kind) begin
            if (mismatch_count_o < REPORT_LIMIT) begin
              $display("Result beat %0d mismatch", checked_o);
              $display("  expected %s", beat_text(want));
              $display("  actual   %s", beat_text(out_data_i));
            end
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_lookups = {pending_lookups, table_access(in_data_i)};
      end
      pending_o <= pending_lookups.size();
    end
  end

endmodule

>>> test/tb_direct_mapped_tagged_entry_table.sv
// ----------------------------------------------------------------------------
// Tagged entry table testbench
// Drives read, write and mirror-read beats into the table, first a directed
// set of corner cases and then random beats drawn mostly from a small pool of
// keys so that hits, same-tag rewrites and collisions are frequent. Both
// channels idle at random. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_direct_mapped_tagged_entry_table;
  import dmt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_BEATS = 1000;
  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES_DEF);
  localparam int unsigned SLOT_POOL    = 8;
  localparam int unsigned TAG_POOL     = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned sent_count [4];
  bit          calm_send = 1'b0;
  bit          calm_recv = 1'b0;

  logic [IDX_W-1:0] slot_pool [SLOT_POOL];
  logic [TAG_W-1:0] tag_pool [TAG_POOL];

  direct_mapped_tagged_entry_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  entry_table_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .pending_o        (outstanding),
    .checked_o        (checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [63:0] pool_key(int unsigned slot_sel, int unsigned tag_sel);
    logic [63:0] k;
    k = rand64();
    k[KEY_W-1:TAG_LSB] = tag_pool[tag_sel];
    k[IDX_W-1:0]       = slot_pool[slot_sel];
    return k;
  endfunction

  function automatic logic [63:0] any_pool_key();
    return pool_key($urandom_range(0, SLOT_POOL - 1), $urandom_range(0, TAG_POOL - 1));
  endfunction

  function automatic in_beat_t make_beat(action_e act, logic [63:0] key, logic [63:0] alt,
                                         logic signed [15:0] score, logic [5:0] depth,
                                         logic [1:0] flag, logic [2:0] mv);
    in_beat_t b;
    b.action    = act;
    b.key       = key;
    b.alt_key   = alt;
    b.score     = score;
    b.depth     = depth;
    b.flag      = flag;
    b.best_move = mv;
    return b;
  endfunction

  function automatic in_beat_t pooled_beat();
    int unsigned r;
    action_e     act;
    logic [63:0] alt;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      act = ACT_READ;
    end else if (r < 60) begin
      act = ACT_WRITE;
    end else if (r < 95) begin
      act = ACT_MIRROR;
    end else begin
      act = ACT_NONE;
    end
    alt = ($urandom_range(0, 4) == 0) ? rand64() : any_pool_key();
    return make_beat(act, any_pool_key(), alt, 16'($urandom), 6'($urandom),
                     2'($urandom), 3'($urandom));
  endfunction

  function automatic in_beat_t noise_beat();
    return make_beat(action_e'($urandom_range(0, 3)), rand64(), rand64(), 16'($urandom),
                     6'($urandom), 2'($urandom), 3'($urandom));
  endfunction

  task automatic send_beat(input in_beat_t beat);
    int unsigned gap;
    gap = calm_send ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count[beat.action]++;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm_recv && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.", outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [63:0] k1;
    logic [63:0] k2;
    logic [63:0] k3;
    logic [63:0] k4;
    logic [63:0] k_zero;
    int unsigned n;
    foreach (sent_count[i]) sent_count[i] = 0;
    slot_pool[0] = '0;
    slot_pool[1] = '1;
    for (n = 2; n < SLOT_POOL; n++) slot_pool[n] = IDX_W'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (n = 2; n < TAG_POOL; n++) tag_pool[n] = TAG_W'(rand64());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    k1     = pool_key(2, 2);
    k2     = pool_key(2, 3);
    k3     = pool_key(3, 2);
    k4     = pool_key(4, 4);
    k_zero = pool_key(5, 0);
    send_beat(make_beat(ACT_READ, '0, '0, 0, 0, 0, 0));
    send_beat(make_beat(ACT_READ, '1, '1, 0, 0, 0, 0));
    send_beat(make_beat(ACT_MIRROR, '1, '1, 0, 0, 0, 0));
    send_beat(make_beat(ACT_WRITE, k1, '0, 16'sh7FFF, 6'd63, 2'd3, 3'd0));
    send_beat(make_beat(ACT_WRITE, pool_key(2, 2), '1, -16'sd32768, 6'd0, 2'd0, 3'd6));
    send_beat(make_beat(ACT_READ, k1, '0, 0, 0, 0, 0));
    send_beat(make_beat(ACT_WRITE, k2, '0, -16'sd1, 6'd5, 2'd1, MOVE_NONE));
    send_beat(make_beat(ACT_READ, k1, '0, 0, 0, 0, 0));
    send_beat(make_beat(ACT_MIRROR, k1, k2, 0, 0, 0, 0));
    send_beat(make_beat(ACT_WRITE, k3, '0, 16'sd100, 6'd10, 2'd2, 3'd2));
    send_beat(make_beat(ACT_MIRROR, k3, k2, 0, 0, 0, 0));
    send_beat(make_beat(ACT_WRITE, k4, '0, -16'sd200, 6'd20, 2'd1, 3'd0));
    send_beat(make_beat(ACT_MIRROR, '1, k4, 0, 0, 0, 0));
    send_beat(make_beat(ACT_WRITE, k_zero, '0, 0, 0, 0, 0));
    send_beat(make_beat(ACT_WRITE, k_zero, '0, 0, 0, 0, 0));
    send_beat(make_beat(ACT_READ, k_zero, '0, 0, 0, 0, 0));
    send_beat(make_beat(ACT_NONE, rand64(), rand64(), 16'($urandom), 6'($urandom),
                        2'($urandom), 3'($urandom)));
    send_beat(make_beat(ACT_WRITE, '1, '0, 16'sd1, 6'd1, 2'd2, 3'd1));
    send_beat(make_beat(ACT_MIRROR, '1, rand64(), 0, 0, 0, 0));
    send_beat(make_beat(ACT_MIRROR, k1, k3, 0, 0, 0, 0));
    send_beat(make_beat(ACT_MIRROR, k1, pool_key(6, 5), 0, 0, 0, 0));

    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 64 == 0) begin
        calm_send = ($urandom_range(0, 3) == 0);
        calm_recv = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 85) begin
        send_beat(pooled_beat());
      end else begin
        send_beat(noise_beat());
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d result beats from %0d reads, %0d writes, %0d mirror reads, %0d unused.",
             checked, sent_count[ACT_READ], sent_count[ACT_WRITE], sent_count[ACT_MIRROR],
             sent_count[ACT_NONE]);
    $display("Corner cases included empty, same-tag, colliding and all-zero slot words.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
